### hdl/sap1_accumulator_cpu_unit_assert.svh
// Assertion macros shared by the checker files of the accumulator CPU unit.
`ifndef SAP1_ACCUMULATOR_CPU_UNIT_ASSERT_SVH
`define SAP1_ACCUMULATOR_CPU_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SAP1_ASSERT_NOW(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sap1 check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SAP1_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sap1 check failed");

`endif

### hdl/sap1_pkg.sv
// ----------------------------------------------------------------------------
// sap1_pkg
// Types, opcodes and constants of the accumulator CPU unit.
// ----------------------------------------------------------------------------
package sap1_pkg;

  localparam int unsigned MEM_WORDS = 16;
  localparam int unsigned MEM_AW    = 4;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_START = 2'd1,
    REQ_STEP  = 2'd2,
    REQ_READ  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_HALTED  = 2'd1,
    ST_INVALID = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  localparam logic [3:0] OP_LDA = 4'h0;
  localparam logic [3:0] OP_ADD = 4'h1;
  localparam logic [3:0] OP_SUB = 4'h2;
  localparam logic [3:0] OP_OUT = 4'hE;
  localparam logic [3:0] OP_HLT = 4'hF;

  // Instruction class, predecoded when a byte is loaded.
  typedef enum logic [1:0] {
    CLS_ALU,
    CLS_OUT,
    CLS_HLT,
    CLS_BAD
  } cls_e;

  typedef enum logic [1:0] {
    ALU_LDA,
    ALU_ADD,
    ALU_SUB
  } alu_e;

  // Work left for the execute stage.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_ALU,
    ACT_OUT,
    ACT_CLEAR,
    ACT_READ
  } act_e;

  typedef struct packed {
    logic       valid;
    act_e       act;
    alu_e       aluop;
    status_e    status;
    logic       strobe;
    logic [3:0] slot;
    logic [3:0] pc;
    logic [3:0] addr;
    logic       mvalid;
  } stage_t;

  function automatic cls_e classify(input logic [3:0] op);
    cls_e c;
    case (op)
      OP_LDA, OP_ADD, OP_SUB: c = CLS_ALU;
      OP_OUT:                 c = CLS_OUT;
      OP_HLT:                 c = CLS_HLT;
      default:                c = CLS_BAD;
    endcase
    return c;
  endfunction

endpackage

### hdl/sap1_if.sv
// ----------------------------------------------------------------------------
// sap1_if
// Request and response channels of the accumulator CPU unit.
// ----------------------------------------------------------------------------
interface sap1_req_if;
  logic               valid;
  logic               ready;
  sap1_pkg::req_e     req_type;
  logic [3:0]         addr;
  logic [7:0]         data;

  modport source (output valid, req_type, addr, data, input ready);
  modport sink   (input valid, req_type, addr, data, output ready);
endinterface

interface sap1_rsp_if;
  logic                 valid;
  logic                 ready;
  sap1_pkg::status_e    status;
  logic                 out_strobe;
  logic [7:0]           out_value;
  logic [3:0]           out_slot;
  logic [7:0]           acc_value;
  logic [3:0]           pc_value;

  modport source (output valid, status, out_strobe, out_value, out_slot, acc_value,
                  pc_value, input ready);
  modport sink   (input valid, status, out_strobe, out_value, out_slot, acc_value,
                  pc_value, output ready);
endinterface

### hdl/sap1_accumulator_cpu_unit.sv
// ----------------------------------------------------------------------------
// sap1_accumulator_cpu_unit
// Tiny accumulator processor with a 16-byte program store and an output store.
// ----------------------------------------------------------------------------
// Takes one request beat per cycle while the response side does not stall,
// and returns one response beat per request, in order. The accepting edge
// also reads the instruction from the program store. The request then moves
// on to the operand read and last to the response register, which is loaded
// together with the registered read of the output store. A stalled response
// holds the whole pipeline. Both stores read as zeros after reset without a
// clearing pass, and a start request clears the output store.
module sap1_accumulator_cpu_unit #(
  parameter int unsigned OUT_SLOTS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sap1_req_if.sink     req_i,
  sap1_rsp_if.source   rsp_o
);
  import sap1_pkg::*;

  logic       adv;
  stage_t     stage;
  logic [7:0] opnd;

  assign req_i.ready = adv;

  sap1_front #(
    .OUT_SLOTS (OUT_SLOTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.req_type),
    .addr_i      (req_i.addr),
    .data_i      (req_i.data),
    .stage_o     (stage),
    .opnd_o      (opnd)
  );

  sap1_exec #(
    .OUT_SLOTS (OUT_SLOTS)
  ) u_exec (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .stage_i      (stage),
    .opnd_i       (opnd),
    .rsp_ready_i  (rsp_o.ready),
    .adv_o        (adv),
    .rsp_valid_o  (rsp_o.valid),
    .status_o     (rsp_o.status),
    .out_strobe_o (rsp_o.out_strobe),
    .out_value_o  (rsp_o.out_value),
    .out_slot_o   (rsp_o.out_slot),
    .acc_value_o  (rsp_o.acc_value),
    .pc_value_o   (rsp_o.pc_value)
  );

endmodule

### hdl/sap1_ram.sv
// ----------------------------------------------------------------------------
// sap1_ram
// Generic synchronous RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sap1_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned Aw   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Read returns the old contents on a same-address write.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/sap1_front.sv
// ----------------------------------------------------------------------------
// sap1_front
// Sequencer and program store: program counter, halt, output index, fetch
// and operand reads of the program store.
// ----------------------------------------------------------------------------
module sap1_front #(
  parameter int unsigned OUT_SLOTS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              req_valid_i,
  input  sap1_pkg::req_e    req_type_i,
  input  logic [3:0]        addr_i,
  input  logic [7:0]        data_i,
  output sap1_pkg::stage_t  stage_o,
  output logic [7:0]        opnd_o
);
  import sap1_pkg::*;

  localparam int unsigned Cw = $clog2(OUT_SLOTS + 1);
  localparam int unsigned Xw = Cw + 4;
  localparam logic [Cw-1:0] SlotsC = Cw'(OUT_SLOTS);

  logic [MEM_AW-1:0] pc_q, pc_d;
  logic              halted_q, halted_d;
  logic [Cw-1:0]     oidx_q, oidx_d;
  logic [Xw-1:0]     oidx_ext;
  cls_e              cls_q [MEM_WORDS];
  cls_e              cls_d [MEM_WORDS];
  logic [MEM_WORDS-1:0] pval_q, pval_d;
  stage_t            s1_q, s1_d, s2_q, s2_d;
  logic              accept;
  logic              prog_we;
  logic [7:0]        fetch_rdata, opnd_rdata, ins;
  cls_e              cls_cur;

  assign accept   = req_valid_i & adv_i;
  assign prog_we  = accept & (req_type_i == REQ_LOAD);
  assign oidx_ext = Xw'(oidx_q);
  assign cls_cur  = cls_q[pc_q];

  // Request stage: all control state is decided here.
  always_comb begin
    pc_d      = pc_q;
    halted_d  = halted_q;
    oidx_d    = oidx_q;
    cls_d     = cls_q;
    pval_d    = pval_q;
    s1_d        = '0;
    s1_d.valid  = accept;
    s1_d.act    = ACT_NONE;
    s1_d.aluop  = ALU_LDA;
    s1_d.status = halted_q ? ST_HALTED : ST_OK;
    s1_d.addr   = addr_i;
    s1_d.mvalid = pval_q[pc_q];
    case (req_type_i)
      REQ_LOAD: begin
        cls_d[addr_i]  = classify(data_i[7:4]);
        pval_d[addr_i] = 1'b1;
      end
      REQ_START: begin
        pc_d        = '0;
        oidx_d      = '0;
        halted_d    = 1'b0;
        s1_d.status = ST_OK;
        s1_d.act    = ACT_CLEAR;
      end
      REQ_STEP: begin
        if (!halted_q) begin
          pc_d        = pc_q + 1'b1;
          s1_d.status = ST_OK;
          case (cls_cur)
            CLS_ALU: s1_d.act = ACT_ALU;
            CLS_OUT: begin
              if (oidx_q != SlotsC) begin
                s1_d.act    = ACT_OUT;
                s1_d.strobe = 1'b1;
                s1_d.slot   = oidx_ext[3:0];
                oidx_d      = oidx_q + 1'b1;
              end else begin
                s1_d.status = ST_FULL;
              end
            end
            CLS_HLT: begin
              halted_d    = 1'b1;
              s1_d.status = ST_HALTED;
            end
            default: begin
              halted_d    = 1'b1;
              s1_d.status = ST_INVALID;
            end
          endcase
        end
      end
      REQ_READ: s1_d.act = ACT_READ;
      default: ;
    endcase
    s1_d.pc = pc_d;
  end

  // Fetch stage: instruction byte is out of the program store.
  assign ins = s1_q.mvalid ? fetch_rdata : 8'h00;

  always_comb begin
    s2_d        = s1_q;
    s2_d.mvalid = pval_q[ins[3:0]];
    case (ins[7:4])
      OP_ADD:  s2_d.aluop = ALU_ADD;
      OP_SUB:  s2_d.aluop = ALU_SUB;
      default: s2_d.aluop = ALU_LDA;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= '0;
      halted_q <= 1'b0;
      oidx_q   <= '0;
      cls_q    <= '{default: CLS_ALU};
      pval_q   <= '0;
      s1_q     <= '0;
      s2_q     <= '0;
    end else begin
      if (accept) begin
        pc_q     <= pc_d;
        halted_q <= halted_d;
        oidx_q   <= oidx_d;
        cls_q    <= cls_d;
        pval_q   <= pval_d;
      end
      if (adv_i) begin
        s1_q <= s1_d;
        s2_q <= s2_d;
      end
    end
  end

  // Two copies of the program store, one per read address.
  sap1_ram #(
    .Width (8),
    .Depth (MEM_WORDS)
  ) u_fetch_ram (
    .clk_i   (clk_i),
    .we_i    (prog_we),
    .waddr_i (addr_i),
    .wdata_i (data_i),
    .re_i    (adv_i),
    .raddr_i (pc_q),
    .rdata_o (fetch_rdata)
  );

  sap1_ram #(
    .Width (8),
    .Depth (MEM_WORDS)
  ) u_opnd_ram (
    .clk_i   (clk_i),
    .we_i    (prog_we),
    .waddr_i (addr_i),
    .wdata_i (data_i),
    .re_i    (adv_i),
    .raddr_i (ins[3:0]),
    .rdata_o (opnd_rdata)
  );

  assign stage_o = s2_q;
  assign opnd_o  = s2_q.mvalid ? opnd_rdata : 8'h00;

endmodule

### hdl/sap1_exec.sv
// ----------------------------------------------------------------------------
// sap1_exec
// Execute stage: accumulator, output store and the response register.
// ----------------------------------------------------------------------------
module sap1_exec #(
  parameter int unsigned OUT_SLOTS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sap1_pkg::stage_t   stage_i,
  input  logic [7:0]         opnd_i,
  input  logic               rsp_ready_i,
  output logic               adv_o,
  output logic               rsp_valid_o,
  output sap1_pkg::status_e  status_o,
  output logic               out_strobe_o,
  output logic [7:0]         out_value_o,
  output logic [3:0]         out_slot_o,
  output logic [7:0]         acc_value_o,
  output logic [3:0]         pc_value_o
);
  import sap1_pkg::*;

  localparam int unsigned Ow = (OUT_SLOTS > 1) ? $clog2(OUT_SLOTS) : 1;
  localparam int unsigned Ew = Ow + 4;

  logic [7:0]           acc_q, acc_d;
  logic [Ow-1:0]        wptr_q, wptr_d;
  logic [OUT_SLOTS-1:0] oval_q, oval_d;
  logic                 out_we;
  logic [Ew-1:0]        addr_ext;
  logic [Ow-1:0]        ridx;
  logic                 rd_hit;
  logic [7:0]           ram_rdata;

  logic                 valid_q;
  status_e              status_q;
  logic                 strobe_q;
  logic [7:0]           value_q;
  logic [3:0]           slot_q;
  logic [7:0]           accv_q;
  logic [3:0]           pc_q;
  logic                 rdsel_q;

  assign adv_o    = !valid_q || rsp_ready_i;
  assign addr_ext = Ew'(stage_i.addr);
  assign ridx     = addr_ext[Ow-1:0];
  assign rd_hit   = stage_i.valid && (stage_i.act == ACT_READ)
                    && (addr_ext < Ew'(OUT_SLOTS)) && oval_q[ridx];
  assign out_we   = adv_o && stage_i.valid && (stage_i.act == ACT_OUT) && stage_i.strobe;

  always_comb begin
    acc_d  = acc_q;
    wptr_d = wptr_q;
    oval_d = oval_q;
    if (stage_i.valid) begin
      case (stage_i.act)
        ACT_ALU: begin
          case (stage_i.aluop)
            ALU_ADD: acc_d = acc_q + opnd_i;
            ALU_SUB: acc_d = acc_q - opnd_i;
            default: acc_d = opnd_i;
          endcase
        end
        ACT_OUT: begin
          if (stage_i.strobe) begin
            oval_d[wptr_q] = 1'b1;
            wptr_d         = wptr_q + 1'b1;
          end
        end
        ACT_CLEAR: begin
          oval_d = '0;
          wptr_d = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      wptr_q  <= '0;
      oval_q  <= '0;
      valid_q <= 1'b0;
      rdsel_q <= 1'b0;
    end else if (adv_o) begin
      acc_q   <= acc_d;
      wptr_q  <= wptr_d;
      oval_q  <= oval_d;
      valid_q <= stage_i.valid;
      rdsel_q <= rd_hit;
    end
  end

  // Response payload; held while the beat is stalled.
  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      status_q <= stage_i.status;
      strobe_q <= stage_i.strobe;
      value_q  <= out_we ? acc_q : 8'h00;
      slot_q   <= stage_i.slot;
      accv_q   <= acc_d;
      pc_q     <= stage_i.pc;
    end
  end

  sap1_ram #(
    .Width (8),
    .Depth (OUT_SLOTS)
  ) u_out_ram (
    .clk_i   (clk_i),
    .we_i    (out_we),
    .waddr_i (wptr_q),
    .wdata_i (acc_q),
    .re_i    (adv_o),
    .raddr_i (ridx),
    .rdata_o (ram_rdata)
  );

  assign rsp_valid_o  = valid_q;
  assign status_o     = status_q;
  assign out_strobe_o = strobe_q;
  assign out_value_o  = rdsel_q ? ram_rdata : value_q;
  assign out_slot_o   = slot_q;
  assign acc_value_o  = accv_q;
  assign pc_value_o   = pc_q;

endmodule

### hdl/sap1_chk.sv
// ----------------------------------------------------------------------------
// sap1_chk
// Port-level checks of the accumulator CPU unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "sap1_accumulator_cpu_unit_assert.svh"

module sap1_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_ready_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [1:0] status_i,
  input logic       out_strobe_i,
  input logic [7:0] out_value_i,
  input logic [3:0] out_slot_i,
  input logic [7:0] acc_value_i,
  input logic [3:0] pc_value_i
);
  import sap1_pkg::*;

  // A stalled response beat keeps its payload.
  `SAP1_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(status_i) && $stable(out_strobe_i) && $stable(out_value_i) && $stable(out_slot_i) && $stable(acc_value_i) && $stable(pc_value_i))

  // A stalled response blocks new requests.
  `SAP1_ASSERT_NOW(a_req_blocked, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, !req_ready_i)

  // OUT leaves the accumulator alone, so the stored value equals it.
  `SAP1_ASSERT_NOW(a_out_value, clk_i, rst_ni, rsp_valid_i && out_strobe_i, (status_i == ST_OK) && (out_value_i == acc_value_i))

endmodule

bind sap1_accumulator_cpu_unit sap1_chk u_sap1_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .status_i     (rsp_o.status),
  .out_strobe_i (rsp_o.out_strobe),
  .out_value_i  (rsp_o.out_value),
  .out_slot_i   (rsp_o.out_slot),
  .acc_value_i  (rsp_o.acc_value),
  .pc_value_i   (rsp_o.pc_value)
);

### dv/sap1_accumulator_cpu_unit_test.sv
// ----------------------------------------------------------------------------
// sap1_accumulator_cpu_unit_test
// Self-checking bench for the accumulator CPU unit.
// ----------------------------------------------------------------------------
// A shadow of the CPU state predicts one response per request beat and checks
// every response beat in order. The stimulus is a short directed program,
// followed by random programs (some of them OUT-heavy to fill the output
// store) and by bursts of random requests. Both channels idle and stall at
// random.
module sap1_accumulator_cpu_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sap1_pkg::*;

  localparam int unsigned OutSlots    = 16;
  localparam int unsigned StimItems   = 1600;
  localparam int unsigned IdleLimit   = 250;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxGap      = 12;

  typedef struct {
    status_e    status;
    logic       strobe;
    logic [7:0] value;
    logic [3:0] slot;
    logic [7:0] acc;
    logic [3:0] pc;
  } cpu_result_t;

  class cpu_shadow;
    logic [7:0]  prog_mem [MEM_WORDS];
    logic [7:0]  out_mem [OutSlots];
    logic [3:0]  pc;
    logic [7:0]  acc;
    int unsigned out_count;
    bit          halted;
    cpu_result_t pending[$];
    int unsigned mismatches;

    function new();
      foreach (prog_mem[i]) prog_mem[i] = '0;
      foreach (out_mem[i]) out_mem[i] = '0;
      pc = '0;
      acc = '0;
      out_count = 0;
      halted = 1'b0;
      mismatches = 0;
    endfunction

    // Advance the shadow by one accepted request and queue its response.
    function void accept_request(req_e kind, logic [3:0] addr, logic [7:0] data);
      cpu_result_t r;
      logic [7:0]  ins;
      logic [7:0]  operand;
      r.status = halted ? ST_HALTED : ST_OK;
      r.strobe = 1'b0;
      r.value  = '0;
      r.slot   = '0;
      case (kind)
        REQ_LOAD: begin
          prog_mem[addr] = data;
        end
        REQ_START: begin
          pc = '0;
          out_count = 0;
          foreach (out_mem[i]) out_mem[i] = '0;
          halted = 1'b0;
          r.status = ST_OK;
        end
        REQ_STEP: begin
          if (!halted) begin
            ins = prog_mem[pc];
            operand = prog_mem[ins[3:0]];
            pc = pc + 4'd1;
            r.status = ST_OK;
            case (ins[7:4])
              OP_LDA: acc = operand;
              OP_ADD: acc = acc + operand;
              OP_SUB: acc = acc - operand;
              OP_OUT: begin
                if (out_count < OutSlots) begin
                  out_mem[out_count] = acc;
                  r.strobe = 1'b1;
                  r.value  = acc;
                  r.slot   = 4'(out_count);
                  out_count++;
                end else begin
                  r.status = ST_FULL;
                end
              end
              OP_HLT: begin
                halted = 1'b1;
                r.status = ST_HALTED;
              end
              default: begin
                halted = 1'b1;
                r.status = ST_INVALID;
              end
            endcase
          end
        end
        default: begin
          if (addr < OutSlots) r.value = out_mem[addr];
        end
      endcase
      r.acc = acc;
      r.pc  = pc;
      pending.push_back(r);
    endfunction

    function void match_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_response(cpu_result_t got);
      cpu_result_t want;
      if (pending.size() == 0) begin
        $error("response beat with no request outstanding");
        mismatches++;
        return;
      end
      want = pending.pop_front();
      match_field("status", want.status, got.status);
      match_field("out_strobe", want.strobe, got.strobe);
      match_field("out_value", want.value, got.value);
      match_field("out_slot", want.slot, got.slot);
      match_field("acc_value", want.acc, got.acc);
      match_field("pc_value", want.pc, got.pc);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  sap1_req_if req_ch ();
  sap1_rsp_if rsp_ch ();

  sap1_accumulator_cpu_unit #(
    .OUT_SLOTS(OutSlots)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .rsp_o (rsp_ch)
  );

  cpu_shadow   shadow = new();
  bit          send_burst = 1'b0;
  bit          take_burst = 1'b0;
  int unsigned sent_count = 0;
  int unsigned idle_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Send one request beat, then hold off for a random gap unless in burst mode.
  task automatic send_beat(req_e kind, logic [3:0] addr, logic [7:0] data);
    int unsigned gap;
    req_ch.req_type <= kind;
    req_ch.addr     <= addr;
    req_ch.data     <= data;
    req_ch.valid    <= 1'b1;
    do @(posedge clk_i); while (!req_ch.ready);
    shadow.accept_request(kind, addr, data);
    sent_count++;
    gap = send_burst ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_step();
    send_beat(REQ_STEP, 4'($urandom), 8'($urandom));
  endtask

  task automatic send_read(logic [3:0] slot);
    send_beat(REQ_READ, slot, 8'($urandom));
  endtask

  function automatic logic [7:0] pick_instr(bit out_heavy);
    int unsigned roll;
    logic [3:0]  op;
    roll = $urandom_range(0, 99);
    if (out_heavy && roll < 95) op = OP_OUT;
    else if (roll < 22) op = OP_LDA;
    else if (roll < 44) op = OP_ADD;
    else if (roll < 66) op = OP_SUB;
    else if (roll < 90) op = OP_OUT;
    else if (roll < 95) op = OP_HLT;
    else op = 4'($urandom_range(3, 13));
    return {op, 4'($urandom)};
  endfunction

  // Load a program (keeping some old bytes), start it and step through it, with reads and loads mixed in.
  task automatic run_program(bit out_heavy);
    int unsigned steps;
    for (int a = 0; a < MEM_WORDS; a++) begin
      if ($urandom_range(0, 3) != 0) begin
        send_beat(REQ_LOAD, 4'(a),
                  ($urandom_range(0, 3) == 0) ? 8'($urandom) : pick_instr(out_heavy));
      end
    end
    send_beat(REQ_START, 4'($urandom), 8'($urandom));
    steps = $urandom_range(1, 40);
    repeat (steps) begin
      case ($urandom_range(0, 19))
        0, 1, 2: send_read(4'($urandom));
        3:       send_beat(REQ_LOAD, 4'($urandom), 8'($urandom));
        default: send_step();
      endcase
    end
    repeat ($urandom_range(0, 4)) send_read(4'($urandom));
  endtask

  task automatic run_noise();
    repeat ($urandom_range(4, 20)) begin
      send_beat(req_e'(2'($urandom)), 4'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    int unsigned directed_count;
    rst_ni          <= 1'b0;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_LOAD;
    req_ch.addr     <= '0;
    req_ch.data     <= '0;
    rsp_ch.ready    <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // LDA 15, ADD 15 (wraps up), LDA 14, SUB 15 (wraps down), OUT, bad opcode
    send_beat(REQ_LOAD, 4'd0, 8'h0F);
    send_beat(REQ_LOAD, 4'd1, 8'h1F);
    send_beat(REQ_LOAD, 4'd2, 8'h0E);
    send_beat(REQ_LOAD, 4'd3, 8'h2F);
    send_beat(REQ_LOAD, 4'd4, 8'hE0);
    send_beat(REQ_LOAD, 4'd5, 8'h30);
    send_beat(REQ_LOAD, 4'd14, 8'h00);
    send_beat(REQ_LOAD, 4'd15, 8'hFF);
    send_beat(REQ_START, 4'd0, 8'h00);
    repeat (6) send_step();
    // Step, read and load while halted
    send_step();
    send_read(4'd0);
    send_read(4'd15);
    send_beat(REQ_LOAD, 4'd0, {OP_HLT, 4'h0});
    // Restart: HLT right away, output store cleared
    send_beat(REQ_START, 4'hF, 8'hFF);
    send_step();
    send_read(4'd0);

    directed_count = sent_count;
    while (sent_count - directed_count < StimItems) begin
      send_burst = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1:    run_noise();
        2, 3:    run_program(1'b1);
        default: run_program(1'b0);
      endcase
    end
    req_ch.valid <= 1'b0;

    while (shadow.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (shadow.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Response side: take beats with random stalls, in and out of burst mode.
  initial begin
    int unsigned stall;
    cpu_result_t got;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    rsp_ch.ready <= 1'b1;
    forever begin
      do @(posedge clk_i); while (!rsp_ch.valid);
      got.status = rsp_ch.status;
      got.strobe = rsp_ch.out_strobe;
      got.value  = rsp_ch.out_value;
      got.slot   = rsp_ch.out_slot;
      got.acc    = rsp_ch.acc_value;
      got.pc     = rsp_ch.pc_value;
      shadow.check_response(got);
      if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
      stall = take_burst ? 0 : $urandom_range(0, MaxGap);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Drop the run when neither channel moves a beat for too long.
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule

### sap1_accumulator_cpu_unit.f
+incdir+hdl
hdl/sap1_pkg.sv
hdl/sap1_if.sv
hdl/sap1_ram.sv
hdl/sap1_front.sv
hdl/sap1_exec.sv
hdl/sap1_accumulator_cpu_unit.sv
hdl/sap1_chk.sv
dv/sap1_accumulator_cpu_unit_test.sv
